// ===== rtl/core/spkm_pkg.sv =====
`timescale 1ns / 1ps

package spkm_pkg;

  // Data path configuration
  localparam int SAMPLE_BITS     = 8;
  localparam int COUNT_BITS      = 16;
  localparam int LIMIT_FRAC_BITS = 16;

  // Field and register widths
  localparam int FIELD_BITS      = 8;
  localparam int BLEN_BITS       = 16;
  localparam int LIMIT_BITS      = 20;
  localparam int POWER_SUM_BITS  = 32;
  localparam int SQUARE_SUM_BITS = 46;
  localparam int POWER_BITS      = 2 * SAMPLE_BITS;
  localparam int SQUARE_BITS     = 2 * POWER_BITS;

  // Block queue between accumulator and SK test
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Shared multiplier of the SK test
  localparam int MUL_BITS  = 32;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int ACC_BITS  = 104;

  // Register reset values
  localparam logic [BLEN_BITS-1:0]  BLEN_RESET  = 16'd256;
  localparam logic [LIMIT_BITS-1:0] LOWER_RESET = 20'd52429;
  localparam logic [LIMIT_BITS-1:0] UPPER_RESET = 20'd78643;

  // Register index (byte address / 4)
  typedef enum logic [1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_LOWER_LIMIT  = 2'd1,
    REG_UPPER_LIMIT  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] sample_re;
    logic signed [FIELD_BITS-1:0] sample_im;
  } sample_t;

  typedef struct packed {
    logic keep;
    logic below_lower;
    logic above_upper;
  } result_t;

  typedef struct packed {
    logic [BLEN_BITS-1:0]  block_length;
    logic [LIMIT_BITS-1:0] lower_limit;
    logic [LIMIT_BITS-1:0] upper_limit;
  } cfg_t;

  // One completed block: sums and effective length
  typedef struct packed {
    logic [POWER_SUM_BITS-1:0]  power_sum;
    logic [SQUARE_SUM_BITS-1:0] square_sum;
    logic [COUNT_BITS-1:0]      n;
  } block_t;

endpackage

// ===== rtl/core/spectral_kurtosis_channel_mask.sv =====
`timescale 1ns / 1ps
// A block with no power gets its result as it leaves the queue; a negative SK ends the
// test after the N*S2 steps. Throughput: one sample per cycle while sample_stall is low;
// the SK test runs 15 multiply-accumulate steps, each a multiply state then an accumulate
// state, on one shared 32x32 multiplier, so blocks shorter than about 32 samples stall
// the input once the two-entry block queue fills.
// Reset (rst, synchronous): clears sums, count, pipeline, queue and result_valid;
// registers return to block_length 256, lower_limit 52429, upper_limit 78643.

module spectral_kurtosis_channel_mask (
  input  logic              clk,
  input  logic              rst,
  // sample channel
  input  logic              sample_valid,
  output logic              sample_stall,
  input  spkm_pkg::sample_t sample,
  // result channel, one item per completed block
  output logic              result_valid,
  input  logic              result_stall,
  output spkm_pkg::result_t result,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  spkm_pkg::cfg_t                 cfg;
  spkm_pkg::reg_idx_t             reg_idx;
  logic                           cfg_write;
  logic                           push;
  spkm_pkg::block_t               push_data;
  logic                           pop;
  spkm_pkg::block_t               head;
  logic [spkm_pkg::FILL_BITS-1:0] fill;

  // Registers sit at byte address 4*i; the low address bits are ignored.
  assign pready    = 1'b1;
  assign reg_idx   = spkm_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_length <= spkm_pkg::BLEN_RESET;
      cfg.lower_limit  <= spkm_pkg::LOWER_RESET;
      cfg.upper_limit  <= spkm_pkg::UPPER_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        spkm_pkg::REG_BLOCK_LENGTH: cfg.block_length <= pwdata[spkm_pkg::BLEN_BITS-1:0];
        spkm_pkg::REG_LOWER_LIMIT:  cfg.lower_limit  <= pwdata[spkm_pkg::LIMIT_BITS-1:0];
        spkm_pkg::REG_UPPER_LIMIT:  cfg.upper_limit  <= pwdata[spkm_pkg::LIMIT_BITS-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      spkm_pkg::REG_BLOCK_LENGTH: prdata = 32'(cfg.block_length);
      spkm_pkg::REG_LOWER_LIMIT:  prdata = 32'(cfg.lower_limit);
      spkm_pkg::REG_UPPER_LIMIT:  prdata = 32'(cfg.upper_limit);
      default:                    prdata = '0;
    endcase
  end

  // Front: power, squared power and block accumulation, one sample per cycle while not stalled.
  spkm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .fill         (fill),
    .push         (push),
    .push_data    (push_data)
  );

  // Finished block sums wait here for the SK test.
  spkm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .fill      (fill)
  );

  // Back: exact SK limit test by cross-multiplication, result register.
  spkm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fill         (fill),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/core/spkm_front.sv =====
`timescale 1ns / 1ps

module spkm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  spkm_pkg::cfg_t                    cfg,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  spkm_pkg::sample_t                 sample,
  input  logic [spkm_pkg::FILL_BITS-1:0]    fill,
  output logic                              push,
  output spkm_pkg::block_t                  push_data
);

  localparam int SB = spkm_pkg::SAMPLE_BITS;
  localparam int CB = spkm_pkg::COUNT_BITS;
  localparam int PB = spkm_pkg::POWER_BITS;
  localparam int QB = spkm_pkg::SQUARE_BITS;
  localparam int RB = spkm_pkg::FILL_BITS + 1;

  logic signed [SB-1:0]   re;
  logic signed [SB-1:0]   im;
  logic signed [2*SB-1:0] re_sq;
  logic signed [2*SB-1:0] im_sq;
  logic [PB-1:0]          power;
  logic [CB-1:0]          n_raw;
  logic [CB-1:0]          n_eff;
  logic [CB:0]            done;
  logic                   last;
  logic                   accept;
  logic [RB-1:0]          reserved;

  logic [CB-1:0] count;

  logic          s1_valid;
  logic          s1_last;
  logic [PB-1:0] s1_power;
  logic [CB-1:0] s1_n;

  logic          s2_valid;
  logic          s2_last;
  logic [PB-1:0] s2_power;
  logic [QB-1:0] s2_square;
  logic [CB-1:0] s2_n;

  logic [spkm_pkg::POWER_SUM_BITS-1:0]  power_sum;
  logic [spkm_pkg::SQUARE_SUM_BITS-1:0] square_sum;
  logic [spkm_pkg::POWER_SUM_BITS-1:0]  power_sum_next;
  logic [spkm_pkg::SQUARE_SUM_BITS-1:0] square_sum_next;

  always_comb begin
    re    = sample.sample_re[SB-1:0];
    im    = sample.sample_im[SB-1:0];
    re_sq = re * re;
    im_sq = im * im;
    power = PB'(re_sq) + PB'(im_sq);

    n_raw = cfg.block_length[CB-1:0];
    n_eff = (n_raw < CB'(2)) ? CB'(2) : n_raw;
    done  = {1'b0, count} + (CB + 1)'(1);
    last  = done >= {1'b0, n_eff};
  end

  // Hold off input while every queue slot is claimed by a block
  // already stored or still in the pipeline.
  assign reserved     = RB'(fill) + RB'(s1_valid && s1_last) + RB'(s2_valid && s2_last);
  assign sample_stall = reserved >= RB'(spkm_pkg::QUEUE_DEPTH);
  assign accept       = sample_valid && !sample_stall;

  assign power_sum_next  = power_sum + spkm_pkg::POWER_SUM_BITS'(s2_power);
  assign square_sum_next = square_sum + spkm_pkg::SQUARE_SUM_BITS'(s2_square);

  assign push      = s2_valid && s2_last;
  assign push_data = '{power_sum: power_sum_next, square_sum: square_sum_next, n: s2_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      power_sum  <= '0;
      square_sum <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        s1_power <= power;
        s1_last  <= last;
        s1_n     <= n_eff;
        count    <= last ? '0 : done[CB-1:0];
      end

      s2_valid <= s1_valid;
      if (s1_valid) begin
        s2_square <= QB'(s1_power) * QB'(s1_power);
        s2_power  <= s1_power;
        s2_last   <= s1_last;
        s2_n      <= s1_n;
      end

      if (s2_valid) begin
        if (s2_last) begin
          power_sum  <= '0;
          square_sum <= '0;
        end else begin
          power_sum  <= power_sum_next;
          square_sum <= square_sum_next;
        end
      end
    end
  end

endmodule

// ===== rtl/core/spkm_queue.sv =====
`timescale 1ns / 1ps

module spkm_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  spkm_pkg::block_t               push_data,
  input  logic                           pop,
  output spkm_pkg::block_t               head,
  output logic [spkm_pkg::FILL_BITS-1:0] fill
);

  localparam int DEPTH = spkm_pkg::QUEUE_DEPTH;
  localparam int PW    = spkm_pkg::PTR_BITS;
  localparam int FW    = spkm_pkg::FILL_BITS;

  spkm_pkg::block_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + FW'(1);
        2'b01:   fill <= fill - FW'(1);
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> fill < FW'(DEPTH))
    else $error("block queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0)
    else $error("block queue read while empty");
`endif

endmodule

// ===== rtl/core/spkm_back.sv =====
`timescale 1ns / 1ps

module spkm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  spkm_pkg::cfg_t                 cfg,
  input  logic [spkm_pkg::FILL_BITS-1:0] fill,
  input  spkm_pkg::block_t               head,
  output logic                           pop,
  output logic                           result_valid,
  input  logic                           result_stall,
  output spkm_pkg::result_t              result
);

  localparam int MB   = spkm_pkg::MUL_BITS;
  localparam int PRB  = spkm_pkg::PROD_BITS;
  localparam int AB   = spkm_pkg::ACC_BITS;
  localparam int CB   = spkm_pkg::COUNT_BITS;
  localparam int SSB  = spkm_pkg::SQUARE_SUM_BITS;
  localparam int DIFF_BITS = CB + SSB;
  localparam int LHS_BITS  = DIFF_BITS + CB + 1;
  localparam int LM_BITS   = spkm_pkg::LIMIT_BITS + CB;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC
  } state_t;

  // Multiply-accumulate steps of the SK test
  typedef enum logic [3:0] {
    OP_S1SQ,
    OP_NS2_LO,
    OP_NS2_HI,
    OP_LHS_LO,
    OP_LHS_HI,
    OP_LO_LIM,
    OP_LO_P00,
    OP_LO_P01,
    OP_LO_P10,
    OP_LO_P11,
    OP_UP_LIM,
    OP_UP_P00,
    OP_UP_P01,
    OP_UP_P10,
    OP_UP_P11
  } op_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } shift_t;

  state_t           state;
  op_t              op;
  spkm_pkg::block_t ent;
  logic [PRB-1:0]   prod;
  logic [AB-1:0]    acc;
  logic [PRB-1:0]   s1sq;
  logic [DIFF_BITS-1:0] diff;
  logic [LHS_BITS-1:0]  lhs;
  logic [LM_BITS-1:0]   lm;
  logic                 below;

  logic [MB-1:0] a_op;
  logic [MB-1:0] b_op;
  logic          acc_clear;
  shift_t        shift;
  logic [AB-1:0] addend;
  logic [AB-1:0] acc_next;
  logic [PRB:0]  ns2_diff;
  logic [AB-1:0] lhs_ext;
  logic          lhs_lt;
  logic          lhs_gt;
  logic [MB-1:0] n_plus;
  logic [MB-1:0] n_minus;

  assign n_plus  = MB'(ent.n) + MB'(1);
  assign n_minus = MB'(ent.n) - MB'(1);

  always_comb begin
    a_op      = '0;
    b_op      = '0;
    acc_clear = 1'b0;
    shift     = SH_0;
    case (op)
      OP_S1SQ: begin
        a_op = ent.power_sum; b_op = ent.power_sum; acc_clear = 1'b1;
      end
      OP_NS2_LO: begin
        a_op = ent.square_sum[MB-1:0]; b_op = MB'(ent.n); acc_clear = 1'b1;
      end
      OP_NS2_HI: begin
        a_op = MB'(ent.square_sum[SSB-1:MB]); b_op = MB'(ent.n); shift = SH_32;
      end
      OP_LHS_LO: begin
        a_op = diff[MB-1:0]; b_op = n_plus; acc_clear = 1'b1;
      end
      OP_LHS_HI: begin
        a_op = MB'(diff[DIFF_BITS-1:MB]); b_op = n_plus; shift = SH_32;
      end
      OP_LO_LIM: begin
        a_op = MB'(cfg.lower_limit); b_op = n_minus; acc_clear = 1'b1;
      end
      OP_UP_LIM: begin
        a_op = MB'(cfg.upper_limit); b_op = n_minus; acc_clear = 1'b1;
      end
      OP_LO_P00, OP_UP_P00: begin
        a_op = lm[MB-1:0]; b_op = s1sq[MB-1:0]; acc_clear = 1'b1;
      end
      OP_LO_P01, OP_UP_P01: begin
        a_op = lm[MB-1:0]; b_op = s1sq[PRB-1:MB]; shift = SH_32;
      end
      OP_LO_P10, OP_UP_P10: begin
        a_op = MB'(lm[LM_BITS-1:MB]); b_op = s1sq[MB-1:0]; shift = SH_32;
      end
      OP_LO_P11, OP_UP_P11: begin
        a_op = MB'(lm[LM_BITS-1:MB]); b_op = s1sq[PRB-1:MB]; shift = SH_64;
      end
      default: begin
        a_op = '0;
      end
    endcase

    case (shift)
      SH_32:   addend = AB'({prod, {MB{1'b0}}});
      SH_64:   addend = AB'({prod, {PRB{1'b0}}});
      default: addend = AB'(prod);
    endcase

    acc_next = (acc_clear ? '0 : acc) + addend;
    // borrow flags a negative SK (N*S2 below S1^2)
    ns2_diff = {1'b0, acc_next[PRB-1:0]} - {1'b0, s1sq};
    lhs_ext  = AB'({lhs, {spkm_pkg::LIMIT_FRAC_BITS{1'b0}}});
    lhs_lt   = lhs_ext < acc_next;
    lhs_gt   = lhs_ext > acc_next;
  end

  assign pop = (state == ST_IDLE) && (fill != '0) && !result_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op           <= OP_S1SQ;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            ent   <= head;
            below <= 1'b0;
            op    <= OP_S1SQ;
            if (head.power_sum == '0) begin
              // no power at all: keep, as a NaN compares
              result       <= spkm_pkg::result_t'{keep: 1'b1, below_lower: 1'b0,
                                                  above_upper: 1'b0};
              result_valid <= 1'b1;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod  <= PRB'(a_op) * PRB'(b_op);
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc <= acc_next;
          op  <= op_t'(op + 4'd1);
          // last step, or a negative SK, ends the test
          if (op == OP_UP_P11 || (op == OP_NS2_HI && ns2_diff[PRB])) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_MUL;
          end
          case (op)
            OP_S1SQ: s1sq <= acc_next[PRB-1:0];
            OP_NS2_HI: begin
              if (ns2_diff[PRB]) begin
                result       <= spkm_pkg::result_t'{keep: 1'b0, below_lower: 1'b1,
                                                    above_upper: 1'b0};
                result_valid <= 1'b1;
              end else begin
                diff <= ns2_diff[DIFF_BITS-1:0];
              end
            end
            OP_LHS_HI: lhs <= acc_next[LHS_BITS-1:0];
            OP_LO_LIM, OP_UP_LIM: lm <= acc_next[LM_BITS-1:0];
            OP_LO_P11: below <= lhs_lt;
            OP_UP_P11: begin
              result       <= spkm_pkg::result_t'{keep: !(below || lhs_gt),
                                                  below_lower: below,
                                                  above_upper: lhs_gt};
              result_valid <= 1'b1;
            end
            default: ;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_flags_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.keep == !(result.below_lower || result.above_upper)))
    else $error("keep disagrees with limit flags");

  a_no_work_while_result_waits: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !result_valid)
    else $error("SK test running while a result is pending");
`endif

endmodule

// ===== tb/sk_flag_checker.sv =====
`timescale 1ns / 1ps

module sk_flag_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  logic              sample_stall,
  input  spkm_pkg::sample_t sample,
  input  logic              result_valid,
  input  logic              result_stall,
  input  spkm_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                bad_count,
  output int                flags_due
);

  localparam int REPORT_LIMIT = 10;

  spkm_pkg::cfg_t                             cfg;
  logic [spkm_pkg::POWER_SUM_BITS-1:0]        power_acc;
  logic [spkm_pkg::SQUARE_SUM_BITS-1:0]       square_acc;
  logic [spkm_pkg::COUNT_BITS-1:0]            fill;
  spkm_pkg::result_t                          flag_q[$];

  // SK limit test by cross-multiplication, all terms held in 128 bits
  function automatic spkm_pkg::result_t sk_flags(
    input logic [spkm_pkg::POWER_SUM_BITS-1:0]  s1,
    input logic [spkm_pkg::SQUARE_SUM_BITS-1:0] s2,
    input logic [spkm_pkg::COUNT_BITS-1:0]      n_eff,
    input logic [spkm_pkg::LIMIT_BITS-1:0]      lo_lim,
    input logic [spkm_pkg::LIMIT_BITS-1:0]      hi_lim
  );
    logic [127:0]      n, ns2, s1sq, lhs, lo_rhs, hi_rhs;
    spkm_pkg::result_t f;
    n    = 128'(n_eff);
    ns2  = 128'(s2);
    ns2  = ns2 * n;
    s1sq = 128'(s1);
    s1sq = s1sq * s1sq;
    f.keep        = 1'b1;
    f.below_lower = 1'b0;
    f.above_upper = 1'b0;
    if (s1 != '0) begin
      if (ns2 < s1sq) begin
        f.below_lower = 1'b1;   // negative SK
      end else begin
        lhs    = ((ns2 - s1sq) * (n + 128'd1)) << spkm_pkg::LIMIT_FRAC_BITS;
        lo_rhs = 128'(lo_lim);
        lo_rhs = lo_rhs * (n - 128'd1) * s1sq;
        hi_rhs = 128'(hi_lim);
        hi_rhs = hi_rhs * (n - 128'd1) * s1sq;
        f.below_lower = (lhs < lo_rhs);
        f.above_upper = (lhs > hi_rhs);
      end
      f.keep = !(f.below_lower || f.above_upper);
    end
    return f;
  endfunction

  always @(posedge clk) begin : watch
    int                                   re, im, pw;
    logic [spkm_pkg::SQUARE_SUM_BITS-1:0] pw_sq;
    logic [spkm_pkg::COUNT_BITS-1:0]      n;
    logic [spkm_pkg::COUNT_BITS:0]        done;
    spkm_pkg::result_t                    want;
    logic [31:0]                          rd_want;
    logic                                 rd_known;
    if (rst) begin
      cfg        = {spkm_pkg::BLEN_RESET, spkm_pkg::LOWER_RESET, spkm_pkg::UPPER_RESET};
      power_acc  = '0;
      square_acc = '0;
      fill       = '0;
      bad_count  = 0;
      flags_due  = 0;
      flag_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (flag_q.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT)
            $display("%0t: result item with none expected: keep=%b below=%b above=%b",
                     $time, result.keep, result.below_lower, result.above_upper);
        end else begin
          want = flag_q.pop_front();
          if (result.keep !== want.keep || result.below_lower !== want.below_lower ||
              result.above_upper !== want.above_upper) begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT)
              $display("%0t: flags mismatch: expected keep=%b below=%b above=%b, got %b %b %b",
                       $time, want.keep, want.below_lower, want.above_upper,
                       result.keep, result.below_lower, result.above_upper);
          end
        end
      end

      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            spkm_pkg::REG_BLOCK_LENGTH: cfg.block_length = pwdata[spkm_pkg::BLEN_BITS-1:0];
            spkm_pkg::REG_LOWER_LIMIT:  cfg.lower_limit  = pwdata[spkm_pkg::LIMIT_BITS-1:0];
            spkm_pkg::REG_UPPER_LIMIT:  cfg.upper_limit  = pwdata[spkm_pkg::LIMIT_BITS-1:0];
            default: ;
          endcase
        end else begin
          rd_known = 1'b1;
          rd_want  = '0;
          case (paddr[3:2])
            spkm_pkg::REG_BLOCK_LENGTH: rd_want = 32'(cfg.block_length);
            spkm_pkg::REG_LOWER_LIMIT:  rd_want = 32'(cfg.lower_limit);
            spkm_pkg::REG_UPPER_LIMIT:  rd_want = 32'(cfg.upper_limit);
            default: rd_known = 1'b0;
          endcase
          if (rd_known && prdata !== rd_want) begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT)
              $display("%0t: register read at %h: expected %h, got %h",
                       $time, paddr, rd_want, prdata);
          end
        end
      end

      if (sample_valid && !sample_stall) begin
        re         = int'(sample.sample_re);
        im         = int'(sample.sample_im);
        pw         = re * re + im * im;
        pw_sq      = spkm_pkg::SQUARE_SUM_BITS'(pw * pw);
        power_acc  = power_acc + spkm_pkg::POWER_SUM_BITS'(pw);
        square_acc = square_acc + pw_sq;
        n = cfg.block_length;
        if (n < spkm_pkg::COUNT_BITS'(2)) n = spkm_pkg::COUNT_BITS'(2);
        done = {1'b0, fill} + (spkm_pkg::COUNT_BITS + 1)'(1);
        if (done < {1'b0, n}) begin
          fill = done[spkm_pkg::COUNT_BITS-1:0];
        end else begin
          flag_q.push_back(sk_flags(power_acc, square_acc, n,
                                    cfg.lower_limit, cfg.upper_limit));
          power_acc  = '0;
          square_acc = '0;
          fill       = '0;
        end
      end
      flags_due = flag_q.size();
    end
  end

endmodule

// ===== tb/spectral_kurtosis_channel_mask_tb.sv =====
`timescale 1ns / 1ps

module spectral_kurtosis_channel_mask_tb;

  // Cycles to let pass once every expected item has arrived: covers the SK
  // test latency and any samples still inside the accumulator pipeline.
  localparam int         DRAIN_CYCLES   = 64;
  localparam logic [1:0] UNUSED_REG_IDX = 2'd3;

  // Shape of the sample stream within one block
  typedef enum int {
    SHAPE_NOISE,    // near-Gaussian, SK around 1
    SHAPE_SPIKY,    // quiet floor with rare bursts, high SK
    SHAPE_TONE,     // constant power, SK at 0
    SHAPE_RAW,      // uniform raw bits
    SHAPE_FULL,     // full-scale corners, fills the accumulators
    SHAPE_SILENT    // all zero, no power
  } shape_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              sample_valid = 1'b0;
  spkm_pkg::sample_t sample       = '0;
  logic              result_stall = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [3:0]        paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic              sample_stall;
  logic              result_valid;
  spkm_pkg::result_t result;
  logic [31:0]       prdata;
  logic              pready;

  int bad_count;
  int flags_due;

  // idle percentages of both sides, and a requested long receiver hold-off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;

  spectral_kurtosis_channel_mask dut (.*);

  sk_flag_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("spectral_kurtosis_channel_mask_tb: FAIL");
    $finish;
  end

  // Result side: random stall, or a long hold-off when one is requested so the
  // block queue fills and the sample input backs up.
  initial begin : recv_side
    int span;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        span         = hold_request;
        hold_request = 0;
        result_stall <= 1'b1;
        repeat (span - 1) @(posedge clk);
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register write with junk above the register width; the block must mask it
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] junk;
    logic [31:0] data;
    junk = $urandom();
    case (idx)
      spkm_pkg::REG_BLOCK_LENGTH:
        data = {junk[31:spkm_pkg::BLEN_BITS], value[spkm_pkg::BLEN_BITS-1:0]};
      spkm_pkg::REG_LOWER_LIMIT,
      spkm_pkg::REG_UPPER_LIMIT:
        data = {junk[31:spkm_pkg::LIMIT_BITS], value[spkm_pkg::LIMIT_BITS-1:0]};
      default: data = junk;
    endcase
    apb_access(1'b1, idx, data);
  endtask

  // Offer one item after a random gap, hold it until accepted
  task automatic send_sample(input spkm_pkg::sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Sender pause: every expected item in, then the pipeline settles
  task automatic wait_drained();
    do @(posedge clk); while (flags_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic spkm_pkg::sample_t make_sample(input shape_t shape, input int amp);
    int re, im;
    re = 0;
    im = 0;
    case (shape)
      SHAPE_NOISE: begin
        re = $urandom_range(63) + $urandom_range(63) + $urandom_range(63)
             + $urandom_range(63) - 126;
        im = $urandom_range(63) + $urandom_range(63) + $urandom_range(63)
             + $urandom_range(63) - 126;
      end
      SHAPE_SPIKY: begin
        if ($urandom_range(15) == 0) begin
          re = $urandom_range(255) - 128;
          im = $urandom_range(255) - 128;
        end else begin
          re = $urandom_range(6) - 3;
          im = $urandom_range(6) - 3;
        end
      end
      SHAPE_TONE: begin
        // same power every item, rotated between the axes
        if ($urandom_range(1)) re = amp;
        else                   im = amp;
      end
      SHAPE_RAW: begin
        re = $urandom_range(255) - 128;
        im = $urandom_range(255) - 128;
      end
      SHAPE_FULL: begin
        re = $urandom_range(1) ? 127 : -128;
        im = $urandom_range(1) ? 127 : -128;
      end
      default: ;
    endcase
    return {re[7:0], im[7:0]};
  endfunction

  function automatic shape_t pick_shape();
    int r;
    r = $urandom_range(99);
    if (r < 45) return SHAPE_NOISE;
    if (r < 60) return SHAPE_SPIKY;
    if (r < 75) return SHAPE_TONE;
    if (r < 85) return SHAPE_RAW;
    if (r < 95) return SHAPE_FULL;
    return SHAPE_SILENT;
  endfunction

  task automatic send_block(input shape_t shape, input int count, input int amp);
    for (int i = 0; i < count; i++)
      send_sample(make_sample(shape, amp));
  endtask

  // Two-sample blocks for the hand-picked cases, then drain
  task automatic send_pair(input spkm_pkg::sample_t a, input spkm_pkg::sample_t b);
    send_sample(a);
    send_sample(b);
    sample_valid <= 1'b0;
    wait_drained();
  endtask

  function automatic spkm_pkg::sample_t corner_sample(input int k);
    case (k)
      0:       return {8'h80, 8'h80};
      1:       return {8'h7F, 8'h7F};
      2:       return {8'h80, 8'h7F};
      3:       return {8'h7F, 8'h80};
      4:       return {8'h00, 8'h00};
      5:       return {8'hFF, 8'hFF};
      6:       return {8'h01, 8'h01};
      7:       return {8'h55, 8'hAA};
      8:       return {8'hAA, 8'h55};
      default: return {8'h00, 8'h80};
    endcase
  endfunction

  // Random batches: new settings, one to three blocks of random shape, the
  // last one sometimes cut short so the next batch starts mid-block (and may
  // lower the length below the current fill).
  task automatic run_random(input int target);
    int     sent, r, blen, eff, nblk, len, amp;
    shape_t shape;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r == 0)      blen = $urandom_range(1);     // treated as 2
      else if (r < 70) blen = $urandom_range(2, 24);
      else if (r < 95) blen = $urandom_range(25, 120);
      else             blen = $urandom_range(121, 400);
      eff = (blen < 2) ? 2 : blen;
      write_reg(spkm_pkg::REG_BLOCK_LENGTH, blen);

      if ($urandom_range(3) != 0) begin
        r = $urandom_range(99);
        if (r < 10)      write_reg(spkm_pkg::REG_LOWER_LIMIT, 0);
        else if (r < 15) write_reg(spkm_pkg::REG_LOWER_LIMIT, 20'hFFFFF);
        else if (r < 20) write_reg(spkm_pkg::REG_LOWER_LIMIT, $urandom_range(20'hFFFFF));
        else             write_reg(spkm_pkg::REG_LOWER_LIMIT, $urandom_range(16384, 65536));
      end
      if ($urandom_range(3) != 0) begin
        r = $urandom_range(99);
        if (r < 10)      write_reg(spkm_pkg::REG_UPPER_LIMIT, 20'hFFFFF);
        else if (r < 15) write_reg(spkm_pkg::REG_UPPER_LIMIT, 0);
        else if (r < 20) write_reg(spkm_pkg::REG_UPPER_LIMIT, $urandom_range(20'hFFFFF));
        else             write_reg(spkm_pkg::REG_UPPER_LIMIT, $urandom_range(65536, 262144));
      end
      if ($urandom_range(4) == 0)
        apb_access(1'b0, 2'($urandom_range(2)), '0);

      nblk = $urandom_range(1, 3);
      for (int b = 0; b < nblk; b++) begin
        shape = pick_shape();
        amp   = $urandom_range(255) - 128;
        len   = eff;
        if (b == nblk - 1 && $urandom_range(4) == 0)
          len = $urandom_range(1, eff - 1);
        send_block(shape, len, amp);
        sent += len;
      end
      sample_valid <= 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- phase 1: sender idles a quarter of cycles, receiver about half ---
    send_idle_pct = 25;
    recv_idle_pct = 53;

    // register reset values
    apb_access(1'b0, spkm_pkg::REG_BLOCK_LENGTH, '0);
    apb_access(1'b0, spkm_pkg::REG_LOWER_LIMIT, '0);
    apb_access(1'b0, spkm_pkg::REG_UPPER_LIMIT, '0);

    // field extremes inside a default-length block, no result yet
    for (int k = 0; k < 10; k++)
      send_sample(corner_sample(k));
    sample_valid <= 1'b0;
    wait_drained();

    // write to the unused index must change nothing
    write_reg(UNUSED_REG_IDX, '0);

    // length lowered mid-block: next item ends it with N=2, SK negative
    write_reg(spkm_pkg::REG_BLOCK_LENGTH, 2);
    send_sample({8'h00, 8'h00});
    sample_valid <= 1'b0;
    wait_drained();

    // length 0 runs as 2; no power at all keeps the channel
    write_reg(spkm_pkg::REG_BLOCK_LENGTH, 0);
    send_pair({8'h00, 8'h00}, {8'h00, 8'h00});

    // length 1 runs as 2; equal power gives SK 0, below the reset lower limit
    write_reg(spkm_pkg::REG_BLOCK_LENGTH, 1);
    send_pair({8'h7F, 8'h00}, {8'h00, 8'h7F});

    // zero limits: SK 0 sits on both, SK 3 exceeds the upper one
    write_reg(spkm_pkg::REG_LOWER_LIMIT, 0);
    write_reg(spkm_pkg::REG_UPPER_LIMIT, 0);
    send_pair({8'h80, 8'h00}, {8'h00, 8'h80});
    send_pair({8'h01, 8'h00}, {8'h00, 8'h00});

    // full-scale limits: SK 3 falls below the lower one
    write_reg(spkm_pkg::REG_LOWER_LIMIT, 20'hFFFFF);
    write_reg(spkm_pkg::REG_UPPER_LIMIT, 20'hFFFFF);
    send_pair({8'h00, 8'h00}, {8'h80, 8'h80});

    // SK exactly 3.0 against limits of exactly 3.0, then one LSB above
    write_reg(spkm_pkg::REG_LOWER_LIMIT, 3 << spkm_pkg::LIMIT_FRAC_BITS);
    write_reg(spkm_pkg::REG_UPPER_LIMIT, 3 << spkm_pkg::LIMIT_FRAC_BITS);
    send_pair({8'h00, 8'h01}, {8'h00, 8'h00});
    write_reg(spkm_pkg::REG_LOWER_LIMIT, (3 << spkm_pkg::LIMIT_FRAC_BITS) + 1);
    send_pair({8'hFF, 8'h00}, {8'h00, 8'h00});
    apb_access(1'b0, spkm_pkg::REG_LOWER_LIMIT, '0);

    run_random(260);

    // --- phase 2: the other way round ---
    send_idle_pct = 53;
    recv_idle_pct = 25;
    run_random(260);

    // --- phase 3: no idling on either side ---
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // receiver holds off for a long stretch while short blocks keep coming,
    // so the block queue fills and sample_stall rises
    write_reg(spkm_pkg::REG_BLOCK_LENGTH, 2);
    hold_request = 400;
    send_block(SHAPE_NOISE, 60, 0);
    sample_valid <= 1'b0;
    wait_drained();

    run_random(240);

    if (bad_count == 0 && flags_due == 0) begin
      $display("spectral_kurtosis_channel_mask_tb: PASS");
    end else begin
      $display("spectral_kurtosis_channel_mask_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/spkm_pkg.sv
rtl/core/spkm_front.sv
rtl/core/spkm_queue.sv
rtl/core/spkm_back.sv
rtl/core/spectral_kurtosis_channel_mask.sv
tb/sk_flag_checker.sv
tb/spectral_kurtosis_channel_mask_tb.sv
